### rtl/core/dmbe_pkg.sv
// ----------------------------------------------------------------------------
// dmbe_pkg
// Types and constants shared by the dot-matrix band encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dmbe_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'd27;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_J     = 8'h4A;
  localparam logic [7:0] CHAR_JL    = 8'h6A;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] FEED_UNITS = 8'd21;
  localparam logic [7:0] JUMP_MAX   = 8'd255;
  localparam logic [7:0] DOT_LIMIT  = 8'd127;
  localparam logic [12:0] COL_LIMIT = 13'd4096;
  localparam logic [12:0] WIDTH_RST = 13'd640;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic OP_COLUMN = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // one queued job for the back end
  typedef struct packed {
    logic        fin;   // finish job: arg holds the return distance
    logic        hdr;   // emit graphics header first
    logic        feed;  // emit line feed after the dot byte
    logic [7:0]  dots;
    logic [12:0] arg;   // band width (column) or distance (finish)
  } desc_t;

  typedef enum logic [2:0] {
    BST_IDLE,
    BST_HDR,
    BST_DATA,
    BST_FEED,
    BST_JUMP
  } bst_t;

endpackage

`default_nettype wire

### rtl/core/dot_matrix_band_encoder.sv
// ----------------------------------------------------------------------------
// dot_matrix_band_encoder
// Flow: an accepted item is queued as a job; the byte sequencer in the back
//   end takes one job at a time, sets the rate, and loads each byte into the
//   registered output stage. Jobs: a column gives a header if first, its dot
//   byte and a feed at band end; a finish gives reversals of up to 255 units.
// Reset: counts, queue and sequencer cleared; band_width returns to 640.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_matrix_band_encoder #(
  parameter int MAX_BANDS = 128
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,    // pix_0 [7:0] .. pix_7 [63:56]
  input  wire         in_tuser,    // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // out_byte
  output logic        out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ADDR_BAND_WIDTH = 3'd0;

  logic [12:0]     band_width_r;
  logic            cfg_wr;
  logic            q_push, q_pop, q_full, q_empty;
  dmbe_pkg::desc_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_BAND_WIDTH) ? {19'd0, band_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_width_r <= dmbe_pkg::WIDTH_RST;
    end else if (cfg_wr && (cfg_paddr == ADDR_BAND_WIDTH)) begin
      band_width_r <= cfg_pwdata[12:0];
    end
  end

  dmbe_front #(
    .MAX_BANDS (MAX_BANDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .band_width (band_width_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  dmbe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dmbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue underflow");

  a_finish_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.fin) |-> (q_wdata.arg != 13'd0))
    else $error("finish job queued with zero distance");

endmodule

`default_nettype wire

### rtl/core/dmbe_front.sv
// ----------------------------------------------------------------------------
// dmbe_front
// Accepts input items, thresholds the pixels, tracks band state and queues
// one job per column, and per finish with nonzero distance, for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dmbe_front #(
  parameter int MAX_BANDS = 128
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [63:0]          in_tdata,
  input  wire                  in_tuser,
  input  wire  [12:0]          band_width,
  input  wire                  q_full,
  output logic                 q_push,
  output dmbe_pkg::desc_t      q_wdata
);

  localparam logic [7:0] MaxBandsC = 8'(MAX_BANDS);

  logic [11:0] column_count_r, column_count_nxt;
  logic [7:0]  band_count_r, band_count_nxt;
  logic [11:0] return_distance_r, return_distance_nxt;

  logic        accept;
  logic [7:0]  dots;
  logic [12:0] limit;
  logic [12:0] col_inc;
  logic        band_end;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      dots[7 - i] = (in_tdata[i*8 +: 8] < dmbe_pkg::DOT_LIMIT);
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign limit     = (band_width > dmbe_pkg::COL_LIMIT) ? dmbe_pkg::COL_LIMIT : band_width;
  assign col_inc   = {1'b0, column_count_r} + 13'd1;
  assign band_end  = (col_inc >= limit);

  always_comb begin
    column_count_nxt    = column_count_r;
    band_count_nxt      = band_count_r;
    return_distance_nxt = return_distance_r;
    q_push              = 1'b0;
    q_wdata             = '0;
    if (accept) begin
      if (in_tuser == dmbe_pkg::OP_FINISH) begin
        q_push              = (return_distance_r != 12'd0);
        q_wdata.fin         = 1'b1;
        q_wdata.arg         = {1'b0, return_distance_r};
        column_count_nxt    = '0;
        band_count_nxt      = '0;
        return_distance_nxt = '0;
      end else begin
        q_push       = 1'b1;
        q_wdata.hdr  = (column_count_r == 12'd0);
        q_wdata.feed = band_end;
        q_wdata.dots = dots;
        q_wdata.arg  = band_width;
        if (band_end) begin
          column_count_nxt = '0;
          if (band_count_r < MaxBandsC) begin
            band_count_nxt      = band_count_r + 8'd1;
            return_distance_nxt = return_distance_r + 12'(dmbe_pkg::FEED_UNITS);
          end
        end else begin
          column_count_nxt = col_inc[11:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r    <= '0;
      band_count_r      <= '0;
      return_distance_r <= '0;
    end else begin
      column_count_r    <= column_count_nxt;
      band_count_r      <= band_count_nxt;
      return_distance_r <= return_distance_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dmbe_fifo.sv
// ----------------------------------------------------------------------------
// dmbe_fifo
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dmbe_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  dmbe_pkg::desc_t      wdata,
  input  wire                  pop,
  output dmbe_pkg::desc_t      rdata,
  output logic                 full,
  output logic                 empty
);

  dmbe_pkg::desc_t slot_r [dmbe_pkg::QUEUE_DEPTH];

  logic [dmbe_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [dmbe_pkg::QUEUE_AW:0]   count_r;

  assign full  = (count_r == (dmbe_pkg::QUEUE_AW+1)'(dmbe_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/dmbe_back.sv
// ----------------------------------------------------------------------------
// dmbe_back
// Takes jobs from the queue and sequences the printer stream bytes into a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dmbe_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  dmbe_pkg::desc_t      q_rdata,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  dmbe_pkg::bst_t  state_r, state_nxt;
  dmbe_pkg::desc_t desc_r, desc_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [11:0]     left_r, left_nxt;

  logic            ovalid_r, ovalid_nxt;
  logic [7:0]      obyte_r, obyte_nxt;
  logic            olast_r, olast_nxt;

  logic            can_load;
  logic [7:0]      jump;
  logic [11:0]     left_sub;

  assign can_load = !ovalid_r || out_tready;
  assign jump     = (left_r > 12'(dmbe_pkg::JUMP_MAX)) ? dmbe_pkg::JUMP_MAX : left_r[7:0];
  assign left_sub = left_r - {4'd0, jump};

  always_comb begin
    state_nxt  = state_r;
    desc_nxt   = desc_r;
    idx_nxt    = idx_r;
    left_nxt   = left_r;
    ovalid_nxt = ovalid_r && !out_tready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    case (state_r)
      dmbe_pkg::BST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          desc_nxt = q_rdata;
          idx_nxt  = '0;
          left_nxt = q_rdata.arg[11:0];
          if (q_rdata.fin) begin
            state_nxt = dmbe_pkg::BST_JUMP;
          end else if (q_rdata.hdr) begin
            state_nxt = dmbe_pkg::BST_HDR;
          end else begin
            state_nxt = dmbe_pkg::BST_DATA;
          end
        end
      end
      dmbe_pkg::BST_HDR: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b0;
          idx_nxt    = idx_r + 2'd1;
          case (idx_r)
            2'd0:    obyte_nxt = dmbe_pkg::ESC_BYTE;
            2'd1:    obyte_nxt = dmbe_pkg::CHAR_L;
            2'd2:    obyte_nxt = desc_r.arg[7:0];
            default: obyte_nxt = {3'd0, desc_r.arg[12:8]};
          endcase
          if (idx_r == 2'd3) begin
            state_nxt = dmbe_pkg::BST_DATA;
          end
        end
      end
      dmbe_pkg::BST_DATA: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = desc_r.dots;
          olast_nxt  = !desc_r.feed;
          idx_nxt    = '0;
          state_nxt  = desc_r.feed ? dmbe_pkg::BST_FEED : dmbe_pkg::BST_IDLE;
        end
      end
      dmbe_pkg::BST_FEED: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = (idx_r == 2'd3);
          idx_nxt    = idx_r + 2'd1;
          case (idx_r)
            2'd0:    obyte_nxt = dmbe_pkg::ESC_BYTE;
            2'd1:    obyte_nxt = dmbe_pkg::CHAR_J;
            2'd2:    obyte_nxt = dmbe_pkg::FEED_UNITS;
            default: obyte_nxt = dmbe_pkg::CR_BYTE;
          endcase
          if (idx_r == 2'd3) begin
            state_nxt = dmbe_pkg::BST_IDLE;
          end
        end
      end
      dmbe_pkg::BST_JUMP: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b0;
          idx_nxt    = idx_r + 2'd1;
          case (idx_r)
            2'd0:    obyte_nxt = dmbe_pkg::ESC_BYTE;
            2'd1:    obyte_nxt = dmbe_pkg::CHAR_JL;
            2'd2:    obyte_nxt = jump;
            default: obyte_nxt = dmbe_pkg::CR_BYTE;
          endcase
          if (idx_r == 2'd3) begin
            left_nxt  = left_sub;
            olast_nxt = (left_sub == 12'd0);
            if (left_sub == 12'd0) begin
              state_nxt = dmbe_pkg::BST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = dmbe_pkg::BST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dmbe_pkg::BST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r  <= desc_nxt;
    idx_r   <= idx_nxt;
    left_r  <= left_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

### verif/dmbe_stream_checker.sv
// ----------------------------------------------------------------------------
// dmbe_stream_checker
// Watches the column, byte and register ports of the band encoder, works out
// the printer byte stream that each accepted item must give, compares every
// emitted byte and its last flag against it, oldest first, and checks reads.
// ----------------------------------------------------------------------------
module dmbe_stream_checker #(
  parameter int         MAX_BANDS  = 128,
  parameter logic [2:0] WIDTH_ADDR = 3'd0
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [63:0] in_tdata,
  input  wire         in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [7:0]  out_tdata,
  input  wire         out_tlast,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  input  wire  [31:0] cfg_prdata,
  input  wire         cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  ESC          = 8'd27;
  localparam logic [7:0]  CR           = 8'd13;
  localparam logic [7:0]  CMD_GRAPHICS = "L";
  localparam logic [7:0]  CMD_FEED     = "J";
  localparam logic [7:0]  CMD_REVERSE  = "j";
  localparam logic [7:0]  FEED_STEP    = 8'd21;
  localparam int unsigned JUMP_LIMIT   = 255;
  localparam logic [7:0]  DARK_LIMIT   = 8'd127;
  localparam int unsigned COLUMN_CAP   = 4096;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  stream_byte_t printer_q[$];
  logic [12:0]  band_width;
  logic [11:0]  col_pos;
  logic [7:0]   band_total;
  logic [11:0]  feed_distance;

  function automatic void queue_byte(input logic [7:0] b);
    printer_q.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void queue_command(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
    queue_byte(a);
    queue_byte(b);
    queue_byte(c);
    queue_byte(d);
  endfunction

  function automatic void encode_item(input logic op, input logic [63:0] pix);
    int unsigned  left;
    int unsigned  jump;
    int unsigned  span;
    int           base;
    int           i;
    logic [7:0]   dots;
    stream_byte_t tail;
    base = printer_q.size();
    if (op == dmbe_pkg::OP_FINISH) begin
      left = feed_distance;
      while (left > 0) begin
        jump = (left > JUMP_LIMIT) ? JUMP_LIMIT : left;
        left -= jump;
        queue_command(ESC, CMD_REVERSE, 8'(jump), CR);
      end
      col_pos       = '0;
      band_total    = '0;
      feed_distance = '0;
    end else begin
      if (col_pos == 0)
        queue_command(ESC, CMD_GRAPHICS, band_width[7:0], {3'b000, band_width[12:8]});
      dots = '0;
      for (i = 0; i < 8; i++)
        if (pix[8*i +: 8] < DARK_LIMIT) dots[7-i] = 1'b1;
      queue_byte(dots);
      span = (band_width > COLUMN_CAP) ? COLUMN_CAP : band_width;
      if (col_pos + 1 >= span) begin
        queue_command(ESC, CMD_FEED, FEED_STEP, CR);
        col_pos = '0;
        if (band_total < MAX_BANDS) begin
          band_total    = band_total + 8'd1;
          feed_distance = feed_distance + 12'(FEED_STEP);
        end
      end else begin
        col_pos = col_pos + 12'd1;
      end
    end
    if (printer_q.size() > base) begin
      tail = printer_q.pop_back();
      tail.last = 1'b1;
      printer_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : watch
    stream_byte_t want;
    if (!rst_n) begin
      band_width    = WIDTH_RESET;
      col_pos       = '0;
      band_total    = '0;
      feed_distance = '0;
      fail_count    = 0;
      printer_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == WIDTH_ADDR) begin
        if (cfg_pwrite) begin
          band_width = cfg_pwdata[12:0];
        end else if (cfg_prdata !== {19'd0, band_width}) begin
          $display("%0t: band_width read exp %0d got %0d", $time, band_width, cfg_prdata);
          fail_count++;
        end
      end
      if (out_tvalid && out_tready) begin
        if (printer_q.size() == 0) begin
          $display("%0t: stray byte exp none got %02h last %0d", $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = printer_q.pop_front();
          if (out_tdata !== want.data) begin
            $display("%0t: out_byte exp %02h got %02h", $time, want.data, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: out_last exp %0d got %0d", $time, want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) encode_item(in_tuser, in_tdata);
    end
    pending = printer_q.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel columns, finish items and band width writes into the band
// encoder under random stalls on both streams; the stream checker beside it
// predicts and compares the printer bytes, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         MAX_BANDS      = 128;
  localparam logic [2:0] REG_BAND_WIDTH = 3'd0;
  localparam int         IDLE_PCT       = 24;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES   = 20;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         HOLD_AFTER     = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // pix_0 [7:0] .. pix_7 [63:56]
  logic        in_tuser;    // op
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // out_byte
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        calm;
  int          fail_count;
  int          pending;
  int          results_seen;

  dot_matrix_band_encoder #(.MAX_BANDS(MAX_BANDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  dmbe_stream_checker #(.MAX_BANDS(MAX_BANDS), .WIDTH_ADDR(REG_BAND_WIDTH)) u_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] gray_level();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 8'($urandom_range(255));
    if (pick < 70) return 8'($urandom_range(135, 120));
    if (pick < 85) return 8'd0;
    return 8'd255;
  endfunction

  function automatic logic [63:0] random_column();
    logic [63:0] v;
    int          i;
    for (i = 0; i < 8; i++) v[8*i +: 8] = gray_level();
    return v;
  endfunction

  function automatic logic [63:0] dark_only(input int idx);
    logic [63:0] v;
    v = '1;
    v[8*idx +: 8] = 8'd0;
    return v;
  endfunction

  task automatic send_item(input logic op, input logic [63:0] pix);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and let the stream drain completely
  task automatic hold_sender();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= REG_BAND_WIDTH;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_band_width(input logic [12:0] w);
    hold_sender();
    apb_access(1'b1, {19'd0, w});
    apb_access(1'b0, 32'd0);
  endtask

  task automatic run_phase(input logic [12:0] w, input int count, input int finish_pct);
    set_band_width(w);
    repeat (count) begin
      if ($urandom_range(99) < finish_pct) send_item(dmbe_pkg::OP_FINISH, random_column());
      else send_item(dmbe_pkg::OP_COLUMN, random_column());
    end
    send_item(dmbe_pkg::OP_FINISH, random_column());
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    calm        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    apb_access(1'b0, 32'd0);

    send_item(dmbe_pkg::OP_COLUMN, '0);
    send_item(dmbe_pkg::OP_COLUMN, '1);
    send_item(dmbe_pkg::OP_COLUMN, {4{8'd127, 8'd126}});
    send_item(dmbe_pkg::OP_COLUMN, dark_only(0));
    send_item(dmbe_pkg::OP_COLUMN, dark_only(7));
    send_item(dmbe_pkg::OP_FINISH, '0);
    send_item(dmbe_pkg::OP_COLUMN, {8{8'h80}});
    send_item(dmbe_pkg::OP_FINISH, '1);
    // zero width: every column closes a band
    set_band_width(13'd0);
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_FINISH, random_column());
    set_band_width(13'd2);
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_FINISH, random_column());
    set_band_width(13'd8191);
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_FINISH, random_column());
    set_band_width(13'd4096);
    send_item(dmbe_pkg::OP_COLUMN, random_column());
    send_item(dmbe_pkg::OP_FINISH, random_column());

    // runs past the band limit, so the finish needs the longest reversal
    run_phase(13'd1, 140, 0);
    run_phase(13'd3, 50, 5);
    run_phase(13'($urandom_range(9, 2)), 50, 4);
    run_phase(13'd0, 30, 10);
    run_phase(13'd640, 30, 3);
    calm = 1'b1;
    run_phase(13'd5, 60, 3);
    calm = 1'b0;
    run_phase(13'd4096, 10, 20);
    run_phase(13'($urandom_range(8191, 4097)), 15, 10);
    run_phase(13'($urandom_range(12, 1)), 40, 5);

    hold_sender();
    if (fail_count == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : result_sink
    bit held;
    held         = 1'b0;
    results_seen = 0;
    out_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) results_seen++;
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

### dot_matrix_band_encoder.f
rtl/core/dmbe_pkg.sv
rtl/core/dmbe_front.sv
rtl/core/dmbe_fifo.sv
rtl/core/dmbe_back.sv
rtl/core/dot_matrix_band_encoder.sv
verif/dmbe_stream_checker.sv
verif/tb_top.sv
